// ===== hw/rtl/ssoc_pkg.sv =====
// Shared types and constants of the sphere slab overlap correspondence core.
`timescale 1ns / 1ps

package ssoc_pkg;

    // Radius width in bits, fixed by the input beat.
    localparam int RAD_BITS = 16;

    // Ratios are Q0.30; this is 1.0.
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Number of quotient bits produced by the ratio divider.
    localparam logic [4:0] DIV_STEPS = 5'd30;

    // Steps of the shared multiplier while one slab piece is evaluated.
    localparam logic [2:0] MS_X2  = 3'd0;  // x*x, x is the radius or the cap height
    localparam logic [2:0] MS_X2F = 3'd1;  // times 3*(b-a) or (3r-h)
    localparam logic [2:0] MS_B2  = 3'd2;  // b*b
    localparam logic [2:0] MS_B3  = 3'd3;  // b*b*b
    localparam logic [2:0] MS_A2  = 3'd4;  // a*a
    localparam logic [2:0] MS_A3  = 3'd5;  // a*a*a

    typedef enum logic [3:0] {
        L_IDLE,
        L_CLR,
        L_SORT_RD,
        L_SORT_KEY,
        L_SORT_CMP,
        L_SORT_PUT,
        L_SP_RD,
        L_SP_CTR,
        L_SP_NB,
        L_SP_NBW,
        L_SP_MUL,
        L_SP_WR,
        L_SUM_WAIT,
        L_SUM_ACC,
        L_DIV,
        L_DONE
    } t_lane_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL1,
        M_MUL2
    } t_merge_state;

    // Status that one axis lane reports to the merging stage.
    typedef struct packed {
        logic        idle;
        logic        done;
        logic        undef;
        logic [30:0] ratio;
    } t_lane_stat;

endpackage

// ===== hw/rtl/ssoc_pt_if.sv =====
// Handshake channel that carries one sphere per beat.
`timescale 1ns / 1ps

interface ssoc_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [15:0]        radius;
    logic               set_tag;
    logic               last_point;

    modport source (
        output valid, center_x, center_y, center_z, radius, set_tag, last_point,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, radius, set_tag, last_point,
        output ready
    );
endinterface

// ===== hw/rtl/ssoc_res_if.sv =====
// Handshake channel that carries one correspondence result per beat.
`timescale 1ns / 1ps

interface ssoc_res_if;
    logic        valid;
    logic        ready;
    logic [30:0] correspondence;
    logic        undefined_ratio;
    logic [8:0]  points_used;

    modport source (
        output valid, correspondence, undefined_ratio, points_used,
        input  ready
    );
    modport sink (
        input  valid, correspondence, undefined_ratio, points_used,
        output ready
    );
endinterface

// ===== hw/rtl/ssoc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ssoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/ssoc_lane.sv =====
// One axis lane: holds its sphere bank, sorts it, spreads volumes onto slabs, divides.
`timescale 1ns / 1ps

module ssoc_lane #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   i_n,
    input  logic                              i_ld_we,
    input  logic [$clog2(MAX_POINTS)-1:0]     i_ld_addr,
    input  logic signed [COORD_BITS-1:0]      i_ld_loc,
    input  logic [ssoc_pkg::RAD_BITS-1:0]     i_ld_rad,
    input  logic                              i_ld_tag,
    output ssoc_pkg::t_lane_stat              o_stat
);
    import ssoc_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int LW = COORD_BITS;
    localparam int PW = LW + RAD_BITS + 1;
    localparam int DW = LW + 1;
    localparam int TW = 128;

    t_lane_state r_state, n_state;

    logic [CW-1:0]        r_n, n_n, r_i, n_i, r_j, n_j, r_c, n_c, r_slab, n_slab;
    logic [PW-1:0]        r_key, n_key;
    logic signed [LW-1:0] r_lc, n_lc;
    logic [RAD_BITS-1:0]  r_r, n_r;
    logic                 r_tag, n_tag, r_dir, n_dir, r_seg, n_seg;
    logic [DW-1:0]        r_a, n_a, r_b, n_b;
    logic [2:0]           r_ms, n_ms;
    logic [49:0]          r_p1, n_p1, r_p2, n_p2, r_p3, n_p3, r_p4, n_p4;
    logic [63:0]          r_num, n_num, r_den, n_den, r_rem, n_rem;
    logic [29:0]          r_q, n_q;
    logic [4:0]           r_dcnt, n_dcnt;
    logic                 r_undef, n_undef;
    logic [30:0]          r_ratio, n_ratio;

    // Point bank and slab totals.
    logic          p_we;
    logic [IW-1:0] p_waddr, p_raddr;
    logic [PW-1:0] p_wdata, p_rdata;
    logic          t_we;
    logic [TW-1:0] t_wdata, t_rdata;

    ssoc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ssoc_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS)) u_tot (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_slab[IW-1:0]),
        .i_wdata (t_wdata),
        .i_raddr (r_slab[IW-1:0]),
        .o_rdata (t_rdata)
    );

    logic signed [LW-1:0] w_rd_loc, w_key_loc;
    logic signed [DW-1:0] w_lc_x, w_nb_x, w_sdiff;
    logic [DW-1:0]        w_diff;
    logic                 w_a_ge_r, w_stop_bwd, w_stop_fwd;
    logic [15:0]          w_a16, w_b16, w_h;
    logic [17:0]          w_f;
    logic [49:0]          w_op_a, w_op_b, w_prod;
    logic [63:0]          w_vol, w_ta, w_tb, w_min;
    logic [64:0]          w_rem2;
    logic                 w_ge;
    logic [29:0]          w_q_next;

    assign w_rd_loc  = p_rdata[LW-1:0];
    assign w_key_loc = r_key[LW-1:0];
    assign w_lc_x    = DW'(r_lc);
    assign w_nb_x    = DW'(w_rd_loc);
    assign w_sdiff   = r_dir ? (w_nb_x - w_lc_x) : (w_lc_x - w_nb_x);
    assign w_diff    = w_sdiff;

    assign w_a_ge_r   = 32'(r_a) >= 32'(r_r);
    assign w_stop_bwd = (r_j == '0) || w_a_ge_r;
    assign w_stop_fwd = ((r_j + 1'b1) >= r_n) || w_a_ge_r;

    // Inside a piece the near distance is below the radius, and for a segment
    // the far distance is too, so both fit the radius width.
    assign w_a16 = 16'(r_a);
    assign w_b16 = 16'(r_b);
    assign w_h   = r_r - w_a16;
    assign w_f   = r_seg ? 18'(18'(w_b16 - w_a16) * 18'd3)
                         : 18'(18'(r_r) * 18'd3 - 18'(w_h));

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_ms)
            MS_X2: begin
                w_op_a = 50'(r_seg ? r_r : w_h);
                w_op_b = 50'(r_seg ? r_r : w_h);
            end
            MS_X2F: begin
                w_op_a = 50'(r_p1[31:0]);
                w_op_b = 50'(w_f);
            end
            MS_B2: begin
                w_op_a = 50'(w_b16);
                w_op_b = 50'(w_b16);
            end
            MS_B3: begin
                w_op_a = 50'(r_p3[31:0]);
                w_op_b = 50'(w_b16);
            end
            MS_A2: begin
                w_op_a = 50'(w_a16);
                w_op_b = 50'(w_a16);
            end
            MS_A3: begin
                w_op_a = 50'(r_p4[31:0]);
                w_op_b = 50'(w_a16);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;
    assign w_vol  = r_seg ? (64'(r_p2) - (64'(r_p3) - 64'(r_p4))) : 64'(r_p2);

    assign w_ta  = t_rdata[63:0];
    assign w_tb  = t_rdata[127:64];
    assign w_min = (w_ta < w_tb) ? w_ta : w_tb;

    assign w_rem2   = {r_rem, 1'b0};
    assign w_ge     = w_rem2 >= {1'b0, r_den};
    assign w_q_next = {r_q[28:0], w_ge};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE:     if (i_start) n_state = (i_n == '0) ? L_SORT_RD : L_CLR;
            L_CLR:      if ((r_slab + 1'b1) >= r_n) n_state = L_SORT_RD;
            L_SORT_RD: begin
                if (r_i >= r_n) n_state = (r_n == '0) ? L_DIV : L_SP_RD;
                else            n_state = L_SORT_KEY;
            end
            L_SORT_KEY: n_state = L_SORT_CMP;
            L_SORT_CMP: begin
                if (w_rd_loc > w_key_loc) begin
                    if (r_j == CW'(1)) n_state = L_SORT_PUT;
                end else begin
                    n_state = L_SORT_RD;
                end
            end
            L_SORT_PUT: n_state = L_SORT_RD;
            L_SP_RD:    n_state = L_SP_CTR;
            L_SP_CTR:   n_state = L_SP_NB;
            L_SP_NB: begin
                if (!r_dir) begin
                    if (!w_stop_bwd) n_state = L_SP_NBW;
                end else if (w_stop_fwd) begin
                    n_state = ((r_c + 1'b1) >= r_n) ? L_SUM_WAIT : L_SP_RD;
                end else begin
                    n_state = L_SP_NBW;
                end
            end
            L_SP_NBW:   n_state = L_SP_MUL;
            L_SP_MUL:   if (r_ms == MS_A3) n_state = L_SP_WR;
            L_SP_WR:    n_state = L_SP_NB;
            L_SUM_WAIT: n_state = L_SUM_ACC;
            L_SUM_ACC:  if ((r_slab + 1'b1) >= r_n) n_state = L_DIV;
                        else n_state = L_SUM_WAIT;
            L_DIV: begin
                if (r_dcnt == '0) begin
                    if (r_den == '0 || r_num >= r_den) n_state = L_DONE;
                end else if (r_dcnt == DIV_STEPS) begin
                    n_state = L_DONE;
                end
            end
            L_DONE:     n_state = L_IDLE;
            default:    n_state = L_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_n = r_n;  n_i = r_i;  n_j = r_j;  n_c = r_c;  n_slab = r_slab;
        n_key = r_key;  n_lc = r_lc;  n_r = r_r;  n_tag = r_tag;  n_dir = r_dir;
        n_seg = r_seg;  n_a = r_a;  n_b = r_b;  n_ms = r_ms;
        n_p1 = r_p1;  n_p2 = r_p2;  n_p3 = r_p3;  n_p4 = r_p4;
        n_num = r_num;  n_den = r_den;  n_rem = r_rem;  n_q = r_q;
        n_dcnt = r_dcnt;  n_undef = r_undef;  n_ratio = r_ratio;
        p_we = 1'b0;  p_waddr = '0;  p_wdata = '0;  p_raddr = '0;
        t_we = 1'b0;  t_wdata = '0;
        unique case (r_state)
            L_IDLE: begin
                p_we    = i_ld_we;
                p_waddr = i_ld_addr;
                p_wdata = {i_ld_tag, i_ld_rad, i_ld_loc};
                if (i_start) begin
                    n_n     = i_n;
                    n_slab  = '0;
                    n_i     = CW'(1);
                    n_num   = '0;
                    n_den   = '0;
                    n_dcnt  = '0;
                    n_undef = 1'b0;
                end
            end
            L_CLR: begin
                t_we   = 1'b1;
                n_slab = r_slab + 1'b1;
            end
            L_SORT_RD: begin
                p_raddr = r_i[IW-1:0];
                if (r_i >= r_n) begin
                    n_c    = '0;
                    n_slab = '0;
                end
            end
            L_SORT_KEY: begin
                n_key   = p_rdata;
                n_j     = r_i;
                p_raddr = IW'(r_i - 1'b1);
            end
            L_SORT_CMP: begin
                p_we    = 1'b1;
                p_waddr = r_j[IW-1:0];
                if (w_rd_loc > w_key_loc) begin
                    p_wdata = p_rdata;
                    n_j     = r_j - 1'b1;
                    p_raddr = IW'(r_j - CW'(2));
                end else begin
                    p_wdata = r_key;
                    n_i     = r_i + 1'b1;
                end
            end
            L_SORT_PUT: begin
                p_we    = 1'b1;
                p_waddr = r_j[IW-1:0];
                p_wdata = r_key;
                n_i     = r_i + 1'b1;
            end
            L_SP_RD: p_raddr = r_c[IW-1:0];
            L_SP_CTR: begin
                n_lc  = w_rd_loc;
                n_r   = p_rdata[LW +: RAD_BITS];
                n_tag = p_rdata[PW-1];
                n_dir = 1'b0;
                n_j   = r_c;
                n_a   = '0;
            end
            L_SP_NB: begin
                if (!r_dir) begin
                    if (w_stop_bwd) begin
                        n_dir = 1'b1;
                        n_j   = r_c;
                        n_a   = '0;
                    end else begin
                        p_raddr = IW'(r_j - 1'b1);
                        n_slab  = r_j - 1'b1;
                    end
                end else if (w_stop_fwd) begin
                    n_c    = r_c + 1'b1;
                    n_slab = '0;
                end else begin
                    p_raddr = IW'(r_j + 1'b1);
                    n_slab  = r_j;
                end
            end
            L_SP_NBW: begin
                n_b   = w_diff;
                n_seg = 32'(r_r) > 32'(w_diff);
                n_ms  = MS_X2;
            end
            L_SP_MUL: begin
                n_ms = r_ms + 1'b1;
                case (r_ms)
                    MS_X2:   n_p1 = w_prod;
                    MS_X2F:  n_p2 = w_prod;
                    MS_B2,
                    MS_B3:   n_p3 = w_prod;
                    default: n_p4 = w_prod;
                endcase
            end
            L_SP_WR: begin
                t_we    = 1'b1;
                t_wdata = r_tag ? {w_tb + w_vol, w_ta} : {w_tb, w_ta + w_vol};
                n_a     = r_b;
                n_j     = r_dir ? (r_j + 1'b1) : (r_j - 1'b1);
            end
            L_SUM_WAIT: ;
            L_SUM_ACC: begin
                n_num  = r_num + {w_min[62:0], 1'b0};
                n_den  = r_den + w_ta + w_tb;
                n_slab = r_slab + 1'b1;
            end
            L_DIV: begin
                if (r_dcnt == '0) begin
                    if (r_den == '0) begin
                        n_undef = 1'b1;
                        n_ratio = '0;
                    end else if (r_num >= r_den) begin
                        n_ratio = Q30_ONE;
                    end else begin
                        n_rem  = r_num;
                        n_q    = '0;
                        n_dcnt = 5'd1;
                    end
                end else begin
                    n_rem  = w_ge ? 64'(w_rem2 - {1'b0, r_den}) : w_rem2[63:0];
                    n_q    = w_q_next;
                    n_dcnt = r_dcnt + 1'b1;
                    if (r_dcnt == DIV_STEPS) n_ratio = {1'b0, w_q_next};
                end
            end
            L_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;  r_i <= n_i;  r_j <= n_j;  r_c <= n_c;  r_slab <= n_slab;
        r_key <= n_key;  r_lc <= n_lc;  r_r <= n_r;  r_tag <= n_tag;  r_dir <= n_dir;
        r_seg <= n_seg;  r_a <= n_a;  r_b <= n_b;  r_ms <= n_ms;
        r_p1 <= n_p1;  r_p2 <= n_p2;  r_p3 <= n_p3;  r_p4 <= n_p4;
        r_num <= n_num;  r_den <= n_den;  r_rem <= n_rem;  r_q <= n_q;
        r_dcnt <= n_dcnt;  r_undef <= n_undef;  r_ratio <= n_ratio;
    end

    assign o_stat.idle  = (r_state == L_IDLE);
    assign o_stat.done  = (r_state == L_DONE);
    assign o_stat.undef = r_undef;
    assign o_stat.ratio = r_ratio;

    // The insertion step never compares against a slot below the bottom.
    a_sort_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_SORT_CMP) |-> (r_j != '0))
        else $error("sort compare reached slot zero");

    // A finished lane goes back to waiting for spheres.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> o_stat.idle)
        else $error("lane did not return to idle after done");

    // The partial remainder stays below the denominator through the division.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DIV && r_dcnt != '0) |-> (r_rem < r_den))
        else $error("divider remainder out of range");
endmodule

// ===== hw/rtl/ssoc_merge.sv =====
// Merging stage: waits for the three axis ratios, multiplies them and holds the result.
`timescale 1ns / 1ps

module ssoc_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [8:0]           i_pts,
    input  ssoc_pkg::t_lane_stat i_stat [3],
    output logic                 o_busy,
    ssoc_res_if.source           o_res
);
    import ssoc_pkg::*;

    t_merge_state r_state, n_state;
    logic [2:0]   r_got, n_got;
    logic         r_valid, n_valid;
    logic [8:0]   r_pts;
    logic [30:0]  r_p, r_out;
    logic         r_und;
    logic [61:0]  w_m1, w_m2;
    logic         w_any_undef;

    assign w_m1        = {31'b0, i_stat[0].ratio} * {31'b0, i_stat[1].ratio};
    assign w_m2        = {31'b0, r_p} * {31'b0, i_stat[2].ratio};
    assign w_any_undef = i_stat[0].undef | i_stat[1].undef | i_stat[2].undef;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE:  if (&r_got) n_state = M_MUL1;
            M_MUL1:  n_state = M_MUL2;
            M_MUL2:  n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_comb begin
        n_got   = r_got | {i_stat[2].done, i_stat[1].done, i_stat[0].done};
        n_valid = r_valid;
        if (o_res.ready) n_valid = 1'b0;
        unique case (r_state)
            M_IDLE:  if (&r_got) n_got = '0;
            M_MUL1:  ;
            M_MUL2:  n_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_got   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_got   <= n_got;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_pts <= i_pts;
        if (r_state == M_MUL1) r_p <= w_m1[60:30];
        if (r_state == M_MUL2) begin
            r_und <= w_any_undef;
            r_out <= w_any_undef ? '0 : w_m2[60:30];
        end
    end

    assign o_busy                = (r_state != M_IDLE) || (r_got != '0);
    assign o_res.valid           = r_valid;
    assign o_res.correspondence  = r_out;
    assign o_res.undefined_ratio = r_und;
    assign o_res.points_used     = r_pts;

    // An undefined ratio always comes with a zero correspondence.
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.undefined_ratio) |-> (o_res.correspondence == '0))
        else $error("undefined ratio with nonzero correspondence");

    // The product of three ratios never exceeds one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.correspondence <= Q30_ONE))
        else $error("correspondence above one");
endmodule

// ===== hw/rtl/sphere_slab_overlap_correspondence_core.sv =====
// Top level of the sphere slab overlap correspondence core.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// i_pt      in   center_x/y/z (Q8.8), radius, set_tag, last_point
// o_res     out  correspondence (Q0.30), undefined_ratio, points_used
//
// Spheres load at one beat per cycle. A beat with last_point starts the
// computation, and no further beat is taken until all three axis lanes are done.
// Per lane: the slab totals are cleared, the spheres are insertion-sorted,
// the volume of each sphere is spread onto the slabs piece by piece, the
// sums are accumulated and the ratio is divided; the slowest lane sets the
// time, then the three ratios are multiplied. Reset is synchronous and
// needs no clearing pass. While a result waits on o_res, spheres of the next
// set still load; only the next last_point beat is held off.

module sphere_slab_overlap_correspondence_core #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssoc_pt_if.sink     i_pt,
    ssoc_res_if.source  o_res
);
    import ssoc_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = (COORD_BITS > 16) ? COORD_BITS : 16;

    // Sphere count of the set being loaded.
    logic [CW-1:0] r_count, n_count;

    logic          w_acc, w_room, w_ld_we, w_start, w_lanes_idle, w_merge_busy;
    logic [CW-1:0] w_n;
    t_lane_stat    w_stat [3];

    logic signed [EW-1:0]         w_ext [3];
    logic signed [COORD_BITS-1:0] w_loc [3];

    // Each coordinate is sign-extended and then cut to the configured width,
    // so a narrow build wraps the coordinate the same way on every axis.
    assign w_ext[0] = EW'(i_pt.center_x);
    assign w_ext[1] = EW'(i_pt.center_y);
    assign w_ext[2] = EW'(i_pt.center_z);

    assign w_lanes_idle = w_stat[0].idle & w_stat[1].idle & w_stat[2].idle;

    // A last_point beat needs the result register free; plain loads do not.
    assign i_pt.ready = w_lanes_idle && !w_merge_busy && !(o_res.valid && i_pt.last_point);

    assign w_acc   = i_pt.valid && i_pt.ready;
    // A sphere beyond the bank size is dropped, but its last_point still counts.
    assign w_room  = 32'(r_count) < 32'(MAX_POINTS);
    assign w_ld_we = w_acc && w_room;
    assign w_start = w_acc && i_pt.last_point;
    assign w_n     = r_count + CW'(w_room);

    always_comb begin
        n_count = r_count;
        if (w_start)      n_count = '0;
        else if (w_ld_we) n_count = r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // One lane per axis, each with its own copy of the sphere bank.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign w_loc[g] = w_ext[g][COORD_BITS-1:0];

        ssoc_lane #(
            .MAX_POINTS (MAX_POINTS),
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_start),
            .i_n       (w_n),
            .i_ld_we   (w_ld_we),
            .i_ld_addr (r_count[IW-1:0]),
            .i_ld_loc  (w_loc[g]),
            .i_ld_rad  (i_pt.radius),
            .i_ld_tag  (i_pt.set_tag),
            .o_stat    (w_stat[g])
        );
    end

    ssoc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_pts   (9'(w_n)),
        .i_stat  (w_stat),
        .o_busy  (w_merge_busy),
        .o_res   (o_res)
    );

    // The load counter never passes the bank size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_POINTS))
        else $error("sphere count above bank size");

    // Once a computation starts, the input stays closed in the next cycle.
    a_start_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !i_pt.ready)
        else $error("input open right after a computation started");

    // Starting a set clears the counter for the next one.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_count == '0))
        else $error("sphere count not cleared at computation start");
endmodule

// ===== bench/tb_ssoc_sb.sv =====
// Scoreboard class that predicts and checks correspondence results.
`timescale 1ns / 1ps

class ssoc_scoreboard;
    int unsigned loaded;
    logic signed [31:0] loc_x [256];
    logic signed [31:0] loc_y [256];
    logic signed [31:0] loc_z [256];
    logic [15:0] rad [256];
    logic tag [256];
    logic [40:0] pending [$];
    int unsigned errors;

    function new();
        loaded = 0;
        errors = 0;
    endfunction

    // Floor of num * 2^30 / den, saturating at 1.0.
    function automatic logic [63:0] ratio_q30(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        if (num >= den) return 64'd1 << 30;
        q = 0;
        r = num;
        for (int i = 0; i < 30; i++) begin
            q = q << 1;
            if (r >= den - r) begin
                r = r - (den - r);
                q[0] = 1'b1;
            end else begin
                r = r + r;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] piece(longint r, longint a, longint b);
        longint h;
        if (r > b) return 3 * r * r * (b - a) - (b * b * b - a * a * a);
        h = r - a;
        return h * h * (3 * r - h);
    endfunction

    // Stable sort along one axis, spread volumes, and return the Q0.30 ratio.
    function automatic logic [63:0] axis_ratio(int ax, output logic zero_den);
        longint lc [256];
        logic [15:0] rr [256];
        logic tt [256];
        logic [63:0] ta [256];
        logic [63:0] tb [256];
        logic [63:0] num;
        logic [63:0] den;
        longint kl;
        longint a;
        longint b;
        logic [15:0] kr;
        logic kt;
        int j;
        int n;
        n = loaded;
        for (int i = 0; i < n; i++) begin
            lc[i] = (ax == 0) ? loc_x[i] : (ax == 1) ? loc_y[i] : loc_z[i];
            rr[i] = rad[i];
            tt[i] = tag[i];
            ta[i] = 0;
            tb[i] = 0;
        end
        for (int i = 1; i < n; i++) begin
            kl = lc[i];
            kr = rr[i];
            kt = tt[i];
            j = i;
            while (j > 0 && lc[j-1] > kl) begin
                lc[j] = lc[j-1];
                rr[j] = rr[j-1];
                tt[j] = tt[j-1];
                j--;
            end
            lc[j] = kl;
            rr[j] = kr;
            tt[j] = kt;
        end
        for (int c = 0; c < n; c++) begin
            for (j = c; j > 0; j--) begin
                a = lc[c] - lc[j];
                b = lc[c] - lc[j-1];
                if (a >= rr[c]) break;
                if (tt[c]) tb[j-1] += piece(rr[c], a, b);
                else ta[j-1] += piece(rr[c], a, b);
            end
            for (j = c; j + 1 < n; j++) begin
                a = lc[j] - lc[c];
                b = lc[j+1] - lc[c];
                if (a >= rr[c]) break;
                if (tt[c]) tb[j] += piece(rr[c], a, b);
                else ta[j] += piece(rr[c], a, b);
            end
        end
        num = 0;
        den = 0;
        for (int i = 0; i < n; i++) begin
            num += 2 * ((ta[i] < tb[i]) ? ta[i] : tb[i]);
            den += ta[i] + tb[i];
        end
        zero_den = (den == 0);
        return zero_den ? 64'd0 : ratio_q30(num, den);
    endfunction

    // Notes one accepted sphere; a set closer queues the expected result.
    function void note_sphere(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] r, logic t, logic last);
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] rz;
        logic [63:0] p;
        logic ux;
        logic uy;
        logic uz;
        if (loaded < 256) begin
            loc_x[loaded] = $signed(x);
            loc_y[loaded] = $signed(y);
            loc_z[loaded] = $signed(z);
            rad[loaded] = r;
            tag[loaded] = t;
            loaded++;
        end
        if (last) begin
            rx = axis_ratio(0, ux);
            ry = axis_ratio(1, uy);
            rz = axis_ratio(2, uz);
            if (ux || uy || uz) begin
                pending.push_back({31'd0, 1'b1, 9'(loaded)});
            end else begin
                p = (rx * ry) >> 30;
                p = (p * rz) >> 30;
                pending.push_back({p[30:0], 1'b0, 9'(loaded)});
            end
            loaded = 0;
        end
    endfunction

    function void check_result(logic [30:0] corr, logic undef, logic [8:0] used);
        logic [40:0] exp_res;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result corr=%0d undef=%0d used=%0d",
                     $time, corr, undef, used);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (exp_res[40:10] !== corr)
            begin
                $display("%0t: correspondence expected %0d actual %0d",
                         $time, exp_res[40:10], corr);
                errors++;
            end
        if (exp_res[9] !== undef) begin
            $display("%0t: undefined_ratio expected %0d actual %0d",
                     $time, exp_res[9], undef);
            errors++;
        end
        if (exp_res[8:0] !== used) begin
            $display("%0t: points_used expected %0d actual %0d",
                     $time, exp_res[8:0], used);
            errors++;
        end
    endfunction
endclass

// ===== bench/tb_top.sv =====
// Top-level testbench of the sphere slab overlap correspondence core.
`timescale 1ns / 1ps

module tb_top;
    import ssoc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    ssoc_scoreboard overlap_sb;

    ssoc_pt_if pt_ch();
    ssoc_res_if res_ch();

    sphere_slab_overlap_correspondence_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pt(pt_ch.sink),
        .o_res(res_ch.source)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("tb_top: errors");
        $finish;
    end

    // Record input beats and check result beats at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && pt_ch.valid && pt_ch.ready)
            overlap_sb.note_sphere(pt_ch.center_x, pt_ch.center_y, pt_ch.center_z,
                                   pt_ch.radius, pt_ch.set_tag, pt_ch.last_point);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            overlap_sb.check_result(res_ch.correspondence, res_ch.undefined_ratio,
                                    res_ch.points_used);
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Leaves valid high after the beat is taken; only an idle cycle or the end
    // of the test drops it, and valid is written once per falling edge.
    task automatic send_sphere(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [15:0] r, logic t, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.center_x <= x;
        pt_ch.center_y <= y;
        pt_ch.center_z <= z;
        pt_ch.radius <= r;
        pt_ch.set_tag <= t;
        pt_ch.last_point <= last;
        @(posedge i_clk);
        while (!pt_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random sphere, mostly in a small cluster so that spheres overlap often.
    task automatic send_random(int spread, logic last);
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] r;
        if ($urandom_range(9) == 0) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
            r = $urandom;
        end else begin
            x = 16'($signed($urandom_range(2 * spread)) - spread);
            y = 16'($signed($urandom_range(2 * spread)) - spread);
            z = 16'($signed($urandom_range(2 * spread)) - spread);
            r = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(spread));
        end
        send_sphere(x, y, z, r, $urandom_range(1), last);
    endtask

    task automatic random_sets(int items);
        int left;
        int n;
        left = items;
        while (left > 0) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(40) + 1 : $urandom_range(11) + 1;
            for (int i = 0; i < n; i++)
                send_random(($urandom_range(3) == 0) ? 8000 : 1200, i == n - 1);
            left -= n;
        end
    endtask

    initial begin
        overlap_sb = new();
        i_rst_n = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        pt_ch.valid = 0;
        pt_ch.center_x = 0;
        pt_ch.center_y = 0;
        pt_ch.center_z = 0;
        pt_ch.radius = 0;
        pt_ch.set_tag = 0;
        pt_ch.last_point = 0;
        res_ch.ready = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: lone sphere, zero-radius set, identical groups, extremes.
        send_sphere(0, 0, 0, 16'h0100, 0, 1);
        send_sphere(16'h7fff, 16'h8000, 0, 16'hffff, 1, 0);
        send_sphere(16'h8000, 16'h7fff, 16'hffff, 16'hffff, 0, 1);
        send_sphere(0, 0, 0, 16'h0200, 0, 0);
        send_sphere(16'h0100, 16'h0100, 16'h0100, 16'h0200, 1, 0);
        send_sphere(16'h0100, 16'h0100, 16'h0100, 16'h0200, 0, 0);
        send_sphere(0, 0, 0, 16'h0200, 1, 1);
        send_sphere(0, 0, 0, 0, 0, 0);
        send_sphere(16'h0010, 16'h0010, 16'h0010, 0, 1, 1);
        send_sphere(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0, 0);
        send_sphere(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1, 0);
        send_sphere(16'h0000, 16'h0000, 16'h0000, 16'h0001, 0, 1);

        // Overflowing load: 260 spheres, the extras are ignored.
        for (int i = 0; i < 260; i++)
            send_random(3000, i == 259);

        // Long hold-off while spheres keep coming.
        hold_cycles = 3000;
        random_sets(60);

        random_sets(220);
        send_idle_pct = 77;
        random_sets(120);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        random_sets(120);
        send_idle_pct = 23;
        recv_stall_pct = 23;
        random_sets(120);
        pt_ch.valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (overlap_sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (overlap_sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
